### hdl/ptaq_pkg.sv
package ptaq_pkg;

    // Item action codes
    localparam logic [1:0] ACT_UPDATE = 2'd0;
    localparam logic [1:0] ACT_DROP   = 2'd1;
    localparam logic [1:0] ACT_CLEAR  = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_ON_THRESHOLD   = 2'd0;
    localparam logic [1:0] REG_OFF_THRESHOLD  = 2'd1;
    localparam logic [1:0] REG_REQUIRED_COUNT = 2'd2;

    // Register reset values
    localparam logic signed [15:0] ON_THRESHOLD_RST   = 16'sd512;
    localparam logic signed [15:0] OFF_THRESHOLD_RST  = 16'sd768;
    localparam logic [7:0]         REQUIRED_COUNT_RST = 8'd3;

    localparam int ID_W    = 16;
    localparam int TTC_W   = 16;
    localparam int DCNT_W  = 8;
    localparam int USE_W   = 6;

    // Per-entry state kept in the state memory
    typedef struct packed {
        logic              alert;
        logic [DCNT_W-1:0] danger_count;
    } track_state_t;

    // Lookup result flags, table to control
    typedef struct packed {
        logic hit;
        logic has_free;
    } lookup_flags_t;

    // Table write command, control to table
    typedef struct packed {
        logic alloc;
        logic release_entry;
        logic wipe;
    } table_cmd_t;

endpackage

### hdl/ptaq_state_mem.sv
module ptaq_state_mem #(
    parameter int DEPTH  = 32,
    parameter int ADDR_W = 5
) (
    input  logic                  clk,
    input  logic                  rd_en,
    input  logic [ADDR_W-1:0]     rd_addr,
    output ptaq_pkg::track_state_t rd_data,
    input  logic                  wr_en,
    input  logic [ADDR_W-1:0]     wr_addr,
    input  ptaq_pkg::track_state_t wr_data
);
    import ptaq_pkg::*;

    track_state_t mem [DEPTH];
    track_state_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hdl/ptaq_table.sv
// Track id table: valid bits and ids in flops, parallel compare, registered
// match vector, lowest-index priority encode.
module ptaq_table #(
    parameter int MAX_TRACKS = 32,
    parameter int IDX_W      = 5
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cmp_en,
    input  logic [ptaq_pkg::ID_W-1:0] probe_id,
    input  ptaq_pkg::table_cmd_t      cmd,
    input  logic [IDX_W-1:0]          cmd_idx,
    input  logic [ptaq_pkg::ID_W-1:0] cmd_id,
    output ptaq_pkg::lookup_flags_t   flags,
    output logic [IDX_W-1:0]          hit_idx,
    output logic [IDX_W-1:0]          free_idx
);
    import ptaq_pkg::*;

    logic [MAX_TRACKS-1:0] used_reg;
    logic [ID_W-1:0]       track_reg [MAX_TRACKS];
    logic [MAX_TRACKS-1:0] match_next;
    logic [MAX_TRACKS-1:0] match_reg;
    logic [MAX_TRACKS-1:0] free_reg;

    always_comb
    begin
        for (int i = 0; i < MAX_TRACKS; i++)
        begin
            match_next[i] = used_reg[i] && (track_reg[i] == probe_id);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg  <= '0;
            match_reg <= '0;
            free_reg  <= '0;
        end
        else
        begin
            if (cmp_en)
            begin
                match_reg <= match_next;
                free_reg  <= ~used_reg;
            end
            if (cmd.wipe)
            begin
                used_reg <= '0;
            end
            else if (cmd.alloc)
            begin
                used_reg[cmd_idx] <= 1'b1;
            end
            else if (cmd.release_entry)
            begin
                used_reg[cmd_idx] <= 1'b0;
            end
        end
    end

    // ids only matter while the valid bit is set
    always_ff @(posedge clk)
    begin
        if (cmd.alloc)
        begin
            track_reg[cmd_idx] <= cmd_id;
        end
    end

    // lowest set bit wins
    always_comb
    begin
        hit_idx  = '0;
        free_idx = '0;
        for (int i = MAX_TRACKS - 1; i >= 0; i--)
        begin
            if (match_reg[i])
            begin
                hit_idx = IDX_W'(i);
            end
            if (free_reg[i])
            begin
                free_idx = IDX_W'(i);
            end
        end
        flags.hit      = |match_reg;
        flags.has_free = |free_reg;
    end

endmodule

### hdl/per_track_alert_qualifier.sv
// Channel  | Handshake            | Payload
// ---------+----------------------+--------------------------------------------
// in       | in_valid / in_ready  | action, obj_id, ttc_ok, ttc_time
// out      | out_valid / out_ready| alert, status, tracks_in_use
// cfg      | cfg_write            | cfg_index, cfg_data (no wait, no read-back)
//
// Each item passes id compare against every table slot at accept, then
// priority encode plus state memory read, then read-modify-write.
// The registered state memory read is why the middle step has its own state.
// Reset clears the valid bits and the track count at once; no clearing pass.
// The result sits in an output register; a stalled beat holds the item in the
// update cycle, and a new beat is taken while a result waits.
module per_track_alert_qualifier #(
    parameter int MAX_TRACKS = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // input channel
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [1:0]                 action,
    input  logic signed [ptaq_pkg::ID_W-1:0]  obj_id,
    input  logic                       ttc_ok,
    input  logic signed [ptaq_pkg::TTC_W-1:0] ttc_time,
    // output channel
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       alert,
    output logic                       status,
    output logic [ptaq_pkg::USE_W-1:0] tracks_in_use,
    // configuration
    input  logic                       cfg_write,
    input  logic [1:0]                 cfg_index,
    input  logic [15:0]                cfg_data
);
    import ptaq_pkg::*;

    localparam int IDX_W = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
    localparam int CNT_W = $clog2(MAX_TRACKS + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_UPD
    } state_t;

    state_t state_reg;

    // configuration
    logic signed [TTC_W-1:0] on_thr_reg;
    logic signed [TTC_W-1:0] off_thr_reg;
    logic [DCNT_W-1:0]       req_cnt_reg;

    // captured item
    logic [1:0]              action_reg;
    logic [ID_W-1:0]         id_reg;
    logic                    ttc_ok_reg;
    logic signed [TTC_W-1:0] ttc_reg;

    // lookup results
    logic                    hit_reg;
    logic                    has_free_reg;
    logic [IDX_W-1:0]        idx_reg;

    logic [CNT_W-1:0]        used_cnt_reg;
    logic [CNT_W-1:0]        used_cnt_next;

    logic                    out_valid_reg;
    logic                    alert_reg;
    logic                    status_reg;
    logic [USE_W-1:0]        tracks_reg;

    lookup_flags_t           flags;
    logic [IDX_W-1:0]        hit_idx;
    logic [IDX_W-1:0]        free_idx;
    logic [IDX_W-1:0]        look_idx;
    table_cmd_t              cmd;

    track_state_t            rd_data;
    track_state_t            cur_state;
    track_state_t            new_state;

    logic                    accept;
    logic                    fire;
    logic                    is_upd;
    logic                    is_drop;
    logic                    is_clear;
    logic                    have_entry;
    logic                    danger;
    logic                    clear_cond;
    logic [DCNT_W-1:0]       cnt_inc;
    logic                    alert_next;
    logic                    status_next;
    logic [CNT_W+USE_W-1:0]  used_ext;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign fire     = (state_reg == ST_UPD) && (!out_valid_reg || out_ready);

    assign look_idx = flags.hit ? hit_idx : free_idx;

    ptaq_table #(
        .MAX_TRACKS (MAX_TRACKS),
        .IDX_W      (IDX_W)
    ) u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmp_en   (accept),
        .probe_id (obj_id),
        .cmd      (cmd),
        .cmd_idx  (idx_reg),
        .cmd_id   (id_reg),
        .flags    (flags),
        .hit_idx  (hit_idx),
        .free_idx (free_idx)
    );

    ptaq_state_mem #(
        .DEPTH  (MAX_TRACKS),
        .ADDR_W (IDX_W)
    ) u_state_mem (
        .clk     (clk),
        .rd_en   (state_reg == ST_LOOK),
        .rd_addr (look_idx),
        .rd_data (rd_data),
        .wr_en   (fire && is_upd && have_entry),
        .wr_addr (idx_reg),
        .wr_data (new_state)
    );

    // update-cycle decisions
    always_comb
    begin
        is_upd     = (action_reg == ACT_UPDATE) && !id_reg[ID_W-1];
        is_drop    = (action_reg == ACT_DROP) && hit_reg;
        is_clear   = (action_reg == ACT_CLEAR);
        have_entry = hit_reg || has_free_reg;

        // a freshly allocated slot starts clean
        cur_state  = hit_reg ? rd_data : '0;

        danger     = ttc_ok_reg && (ttc_reg <= on_thr_reg);
        clear_cond = !ttc_ok_reg || (ttc_reg >= off_thr_reg);
        cnt_inc    = (cur_state.danger_count < req_cnt_reg)
                     ? cur_state.danger_count + DCNT_W'(1)
                     : cur_state.danger_count;

        new_state = cur_state;
        if (cur_state.alert)
        begin
            if (clear_cond)
            begin
                new_state = '0;
            end
        end
        else if (danger)
        begin
            new_state.danger_count = cnt_inc;
            new_state.alert        = (cnt_inc >= req_cnt_reg);
        end
        else
        begin
            new_state.danger_count = '0;
        end

        cmd.alloc         = fire && is_upd && !hit_reg && has_free_reg;
        cmd.release_entry = fire && is_drop;
        cmd.wipe          = fire && is_clear;

        used_cnt_next = used_cnt_reg;
        if (is_clear)
        begin
            used_cnt_next = '0;
        end
        else if (is_upd && !hit_reg && has_free_reg)
        begin
            used_cnt_next = used_cnt_reg + CNT_W'(1);
        end
        else if (is_drop && (used_cnt_reg != '0))
        begin
            used_cnt_next = used_cnt_reg - CNT_W'(1);
        end

        alert_next  = is_upd && have_entry && new_state.alert;
        status_next = is_upd && !have_entry;
        used_ext    = {{USE_W{1'b0}}, used_cnt_next};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            on_thr_reg    <= ON_THRESHOLD_RST;
            off_thr_reg   <= OFF_THRESHOLD_RST;
            req_cnt_reg   <= REQUIRED_COUNT_RST;
            used_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
            alert_reg     <= 1'b0;
            status_reg    <= 1'b0;
            tracks_reg    <= '0;
            hit_reg       <= 1'b0;
            has_free_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_ON_THRESHOLD:   on_thr_reg  <= cfg_data;
                    REG_OFF_THRESHOLD:  off_thr_reg <= cfg_data;
                    REG_REQUIRED_COUNT: req_cnt_reg <= cfg_data[DCNT_W-1:0];
                    default: ;
                endcase
            end

            if (out_valid_reg && out_ready && !fire)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= ST_LOOK;
                    end
                end
                ST_LOOK:
                begin
                    hit_reg      <= flags.hit;
                    has_free_reg <= flags.has_free;
                    state_reg    <= ST_UPD;
                end
                ST_UPD:
                begin
                    if (fire)
                    begin
                        used_cnt_reg  <= used_cnt_next;
                        out_valid_reg <= 1'b1;
                        alert_reg     <= alert_next;
                        status_reg    <= status_next;
                        tracks_reg    <= used_ext[USE_W-1:0];
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // item payload and slot index, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            action_reg <= action;
            id_reg     <= obj_id;
            ttc_ok_reg <= ttc_ok;
            ttc_reg    <= ttc_time;
        end
        if (state_reg == ST_LOOK)
        begin
            idx_reg <= look_idx;
        end
    end

    assign out_valid     = out_valid_reg;
    assign alert         = alert_reg;
    assign status        = status_reg;
    assign tracks_in_use = tracks_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_cnt_reg <= CNT_W'(MAX_TRACKS))
        else $error("track count above table size");

    a_alloc_inc: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.alloc |=> used_cnt_reg == $past(used_cnt_reg) + CNT_W'(1))
        else $error("allocation did not bump track count");

    a_wipe_zero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wipe |=> (used_cnt_reg == '0) && (tracks_reg == '0))
        else $error("table clear left tracks counted");

    a_full_no_alert: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(alert_reg && status_reg))
        else $error("alert raised on a full-table result");
`endif

endmodule
